>>> design/indexed_shift_queue_unit_assert.svh
// Assertion macros for the indexed shift queue.
`ifndef INDEXED_SHIFT_QUEUE_UNIT_ASSERT_SVH
`define INDEXED_SHIFT_QUEUE_UNIT_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ISQ_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("indexed shift queue assertion failed");

// Concurrent assertion on the block clock and reset.
`define ISQ_ASSERT(lbl, prop) \
  `ISQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

>>> design/isq_pkg.sv
`timescale 1ns / 1ps

package isq_pkg;

  // Position width: covers a 5-bit request index and any capacity up to 256.
  localparam int unsigned PosW = 9;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_READ   = 3'd2,
    ACT_APPEND = 3'd3,
    ACT_POP    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [PosW-1:0] pos;
  } cell_op_t;

endpackage

>>> design/isq_cell.sv
`timescale 1ns / 1ps

module isq_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  isq_pkg::cell_op_t     op_i,
  input  logic [DATA_WIDTH-1:0] new_word_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] word_o
);
  import isq_pkg::*;

  localparam logic [PosW-1:0] MyPos = PosW'(IDX);

  logic [DATA_WIDTH-1:0] word_q;
  logic [DATA_WIDTH-1:0] word_d;

  always_comb begin
    word_d = word_q;
    if (op_i.ins) begin
      if (MyPos == op_i.pos) begin
        word_d = new_word_i;
      end else if (MyPos > op_i.pos) begin
        word_d = left_i;
      end
    end else if (op_i.rem) begin
      if (MyPos >= op_i.pos) begin
        word_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

>>> design/indexed_shift_queue_unit.sv
`timescale 1ns / 1ps
// Indexed shift queue: ordered queue of data words packed from position 0.
// Request channel: in_valid_i / in_stall_o with action_i, index_i, element_i.
// Actions: insert at index, remove at index, read at index, append, pop front.
// Result channel: out_valid_o / out_stall_i with element_out_o, count_o,
// status_o (ok, full, empty, index out of range). One result per request.
// Each request is done in the cycle it is taken: a row of CAPACITY cells
// shifts up or down in parallel, so out_valid_o rises in the cycle after
// acceptance and one request per cycle is taken while in_stall_o is low.
// The result register is the only buffer: while a result waits under
// out_stall_i, in_stall_o is high and no request is taken; a result taken in
// the same cycle lets the next request in.
// Reset empties the queue (count 0) and clears the result valid; stored words
// are not cleared and are never visible before they are written.
// Failed requests leave the queue unchanged and return element_out_o = 0.

module indexed_shift_queue_unit #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [4:0]  index_i,
  input  logic [31:0] element_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] element_out_o,
  output logic [4:0]  count_o,
  output logic [1:0]  status_o
);
  import isq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned MaxW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

  logic [CntW-1:0]       count_q, count_d;
  logic                  out_valid_q;
  logic [31:0]           elem_out_q;
  logic [4:0]            cnt_out_q;
  status_e               status_q;

  logic                  accept;
  logic [PosW-1:0]       pos;
  logic [PosW-1:0]       cnt_pos;
  logic                  full, empty;
  logic                  ins_ok, rem_ok, rd_ok;
  status_e               status_d;
  cell_op_t              op;
  logic [MaxW-1:0]       in_wide;
  logic [MaxW-1:0]       rd_wide;
  logic [DATA_WIDTH-1:0] new_word;
  logic [DATA_WIDTH-1:0] rd_word;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign cnt_pos = PosW'(count_q);
  assign full    = (count_q == CntW'(CAPACITY));
  assign empty   = (count_q == '0);

  always_comb begin
    pos      = PosW'(index_i);
    ins_ok   = 1'b0;
    rem_ok   = 1'b0;
    rd_ok    = 1'b0;
    status_d = ST_OK;
    case (action_e'(action_i))
      ACT_INSERT, ACT_APPEND: begin
        if (action_e'(action_i) == ACT_APPEND) begin
          pos = cnt_pos;
        end
        if (full) begin
          status_d = ST_FULL;
        end else if (pos > cnt_pos) begin
          status_d = ST_RANGE;
        end else begin
          ins_ok = 1'b1;
        end
      end
      ACT_REMOVE, ACT_READ, ACT_POP: begin
        if (action_e'(action_i) == ACT_POP) begin
          pos = '0;
        end
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (pos >= cnt_pos) begin
          status_d = ST_RANGE;
        end else if (action_e'(action_i) == ACT_READ) begin
          rd_ok = 1'b1;
        end else begin
          rem_ok = 1'b1;
        end
      end
      default: begin
        status_d = ST_RANGE;
      end
    endcase
  end

  assign in_wide  = MaxW'(element_i);
  assign new_word = in_wide[DATA_WIDTH-1:0];

  assign op.ins = accept & ins_ok;
  assign op.rem = accept & rem_ok;
  assign op.pos = pos;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_q[i+1];
    end
    isq_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .IDX       (i)
    ) u_cell (
      .clk_i     (clk_i),
      .op_i      (op),
      .new_word_i(new_word),
      .left_i    (left_w),
      .right_i   (right_w),
      .word_o    (cell_q[i])
    );
  end

  // Tap of the addressed cell.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (pos == PosW'(i)) begin
        rd_word = rd_word | cell_q[i];
      end
    end
  end

  assign rd_wide = MaxW'(rd_word);

  always_comb begin
    count_d = count_q;
    if (op.ins) begin
      count_d = count_q + CntW'(1);
    end else if (op.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= accept | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      elem_out_q <= (rd_ok | rem_ok) ? rd_wide[31:0] : 32'd0;
      cnt_out_q  <= 5'(count_d);
      status_q   <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign element_out_o = elem_out_q;
  assign count_o       = cnt_out_q;
  assign status_o      = status_q;

endmodule

>>> design/isq_checker.sv
`timescale 1ns / 1ps
`include "indexed_shift_queue_unit_assert.svh"

module isq_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] element_out_o,
  input logic [4:0]  count_o,
  input logic [1:0]  status_o
);
  import isq_pkg::*;

  `ISQ_ASSERT(a_held_result, out_valid_o && out_stall_i |=> out_valid_o && $stable(element_out_o) && $stable(count_o) && $stable(status_o))
  `ISQ_ASSERT(a_stall_only_on_held, in_stall_o |-> out_valid_o && out_stall_i)
  `ISQ_ASSERT(a_fail_no_data, out_valid_o && status_o != ST_OK |-> element_out_o == 32'd0)
  `ISQ_ASSERT(a_empty_count, out_valid_o && status_o == ST_EMPTY |-> count_o == 5'd0)
  `ISQ_ASSERT(a_full_count, out_valid_o && status_o == ST_FULL |-> count_o == 5'(CAPACITY))

endmodule

bind indexed_shift_queue_unit isq_checker #(.CAPACITY(CAPACITY)) u_isq_checker (.*);

>>> tb/indexed_shift_queue_unit_test.sv
`timescale 1ns / 1ps

module indexed_shift_queue_unit_test;
  import isq_pkg::*;

  localparam int unsigned CAPACITY = 16;
  localparam logic [2:0] ACT_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] ACT_RESERVED_LAST = 3'd7;
  localparam int BIAS_GROW = 0;
  localparam int BIAS_SHRINK = 1;
  localparam int BIAS_EVEN = 2;
  localparam int PHASES = 27;
  localparam int PHASE_REQUESTS = 60;
  localparam int QUIET_PHASES = 3;
  localparam int SETTLE_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [31:0] word;
    logic [4:0]  count;
    status_e     status;
  } queue_result_t;

  class shift_queue_mirror;
    logic [31:0]   slots[CAPACITY];
    int            fill = 0;
    queue_result_t awaiting[$];
    int            failures = 0;

    function void note_request(logic [2:0] act, logic [4:0] idx, logic [31:0] word);
      queue_result_t r;
      int pos;
      int i;
      r.word = '0;
      r.status = ST_OK;
      pos = int'(idx);
      case (act)
        ACT_INSERT, ACT_APPEND: begin
          if (act == ACT_APPEND) pos = fill;
          if (fill >= CAPACITY) begin
            r.status = ST_FULL;
          end else if (pos > fill) begin
            r.status = ST_RANGE;
          end else begin
            for (i = fill; i > pos; i--) slots[i] = slots[i-1];
            slots[pos] = word;
            fill++;
          end
        end
        ACT_REMOVE, ACT_READ, ACT_POP: begin
          if (act == ACT_POP) pos = 0;
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else if (pos >= fill) begin
            r.status = ST_RANGE;
          end else begin
            r.word = slots[pos];
            if (act != ACT_READ) begin
              for (i = pos; i + 1 < fill; i++) slots[i] = slots[i+1];
              fill--;
            end
          end
        end
        default: r.status = ST_RANGE;
      endcase
      r.count = fill[4:0];
      awaiting.push_back(r);
    endfunction

    function void check_result(logic [31:0] word, logic [4:0] cnt, logic [1:0] st);
      queue_result_t r;
      if (awaiting.size() == 0) begin
        $error("unexpected result: element_out %h count %0d status %0d", word, cnt, st);
        failures++;
        return;
      end
      r = awaiting.pop_front();
      if (word !== r.word) begin
        $error("element_out mismatch: expected %h, actual %h", r.word, word);
        failures++;
      end
      if (cnt !== r.count) begin
        $error("count mismatch: expected %0d, actual %0d", r.count, cnt);
        failures++;
      end
      if (st !== r.status) begin
        $error("status mismatch: expected %0d, actual %0d", r.status, st);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  action_i = ACT_READ;
  logic [4:0]  index_i = '0;
  logic [31:0] element_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] element_out_o;
  logic [4:0]  count_o;
  logic [1:0]  status_o;

  logic sender_idling = 1'b0;
  logic receiver_idling = 1'b0;
  int   quiet_cycles = 0;

  shift_queue_mirror mirror = new;

  indexed_shift_queue_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .index_i       (index_i),
    .element_i     (element_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .element_out_o (element_out_o),
    .count_o       (count_o),
    .status_o      (status_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      mirror.check_result(element_out_o, count_o, status_o);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (receiver_idling && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("indexed_shift_queue_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [2:0] act, input logic [4:0] idx,
                              input logic [31:0] word);
    if (sender_idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    index_i    <= idx;
    element_i  <= word;
    do @(posedge clk_i); while (in_stall_o);
    mirror.note_request(act, idx, word);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (mirror.awaiting.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_request(input int bias);
    int          grow;
    int          roll;
    int          cnt;
    logic [2:0]  act;
    logic [4:0]  idx;
    logic [31:0] word;
    grow = (bias == BIAS_GROW) ? 60 : (bias == BIAS_SHRINK) ? 25 : 42;
    cnt = mirror.fill;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      act = 3'($urandom_range(ACT_RESERVED_FIRST, ACT_RESERVED_LAST));
    end else if (roll < 15) begin
      act = ACT_READ;
    end else if (roll < 15 + grow) begin
      act = $urandom_range(0, 1) ? ACT_INSERT : ACT_APPEND;
    end else begin
      act = $urandom_range(0, 1) ? ACT_REMOVE : ACT_POP;
    end
    if ($urandom_range(0, 9) == 0 || act == ACT_APPEND || act == ACT_POP) begin
      idx = 5'($urandom_range(0, 31));
    end else if (act == ACT_INSERT) begin
      idx = 5'($urandom_range(0, cnt));
    end else begin
      idx = (cnt == 0) ? 5'd0 : 5'($urandom_range(0, cnt - 1));
    end
    case ($urandom_range(0, 15))
      0: word = '0;
      1: word = '1;
      default: word = $urandom;
    endcase
    send_request(act, idx, word);
  endtask

  initial begin
    int          k;
    int          code;
    int          phase;
    logic [31:0] word;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue
    send_request(ACT_POP, 5'd0, '1);
    send_request(ACT_REMOVE, 5'd0, '0);
    send_request(ACT_READ, 5'd0, '0);
    send_request(ACT_INSERT, 5'd1, 32'h1234_5678);
    for (code = ACT_RESERVED_FIRST; code <= ACT_RESERVED_LAST; code++) begin
      send_request(code[2:0], 5'd31, '1);
    end

    // fill from head, tail, middle and at the count
    for (k = 0; k < CAPACITY; k++) begin
      word = (k == 0) ? '0 : (k == 1) ? '1 : $urandom;
      case (k % 4)
        0: send_request(ACT_INSERT, 5'd0, word);
        1: send_request(ACT_APPEND, 5'd0, word);
        2: send_request(ACT_INSERT, k[5:1], word);
        default: send_request(ACT_INSERT, k[4:0], word);
      endcase
    end
    send_request(ACT_APPEND, 5'd0, '1);
    send_request(ACT_INSERT, 5'd0, '0);
    send_request(ACT_READ, 5'd15, '0);
    send_request(ACT_READ, 5'd31, '0);
    send_request(ACT_REMOVE, 5'd16, '0);
    send_request(ACT_REMOVE, 5'd7, '0);
    send_request(ACT_POP, 5'd0, '0);
    wait_for_results();

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase < PHASES - QUIET_PHASES) begin
        sender_idling   <= ($urandom_range(0, 3) != 0);
        receiver_idling <= ($urandom_range(0, 3) != 0);
      end else begin
        sender_idling   <= 1'b0;
        receiver_idling <= 1'b0;
      end
      repeat (PHASE_REQUESTS) random_request(phase % 3);
      if (phase == PHASES / 2) wait_for_results();
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mirror.failures == 0 && mirror.awaiting.size() == 0) begin
      $display("indexed_shift_queue_unit test passed");
    end else begin
      if (mirror.awaiting.size() != 0) begin
        $error("%0d results never arrived", mirror.awaiting.size());
      end
      $display("indexed_shift_queue_unit test failed");
    end
    $finish;
  end

endmodule
